>>> rtl/wu_line_pixel_generator_macros.svh
// assertion macros for the wu line pixel generator
// no dependencies; included by the top level
`ifndef WU_LINE_PIXEL_GENERATOR_MACROS_SVH
`define WU_LINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define WLPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define WLPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/wlpg_pkg.sv
// shared constants, types and pixel helper for the wu line pixel generator
// no dependencies
package wlpg_pkg;

   localparam int COORD_BITS     = 12;
   localparam int FRAC_BITS      = 16;
   localparam int POS_BITS       = COORD_BITS + FRAC_BITS;
   localparam int SLOPE_BITS     = FRAC_BITS + 2;
   localparam int DIVIDEND_BITS  = COORD_BITS + FRAC_BITS;
   localparam int DIV_COUNT_BITS = $clog2(DIVIDEND_BITS);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS:0]   y;
      logic                  last;
   } pixel_type;

   // map major/minor back to original axes
   function automatic pixel_type make_pixel(input logic                  steep,
                                            input logic [COORD_BITS-1:0] major,
                                            input logic [COORD_BITS:0]   minor,
                                            input logic                  last);
      pixel_type p;
      p.x    = steep ? minor[COORD_BITS-1:0] : major;
      p.y    = steep ? {1'b0, major} : minor;
      p.last = last;
      return p;
   endfunction

endpackage

>>> rtl/wlpg_div.sv
// restoring shift-subtract divider, one quotient bit per cycle
// depends on wlpg_pkg
module wlpg_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [wlpg_pkg::DIVIDEND_BITS-1:0]    dividend,
   input  logic [wlpg_pkg::COORD_BITS-1:0]       divisor,
   output wlpg_pkg::div_status_type              status,
   output logic [wlpg_pkg::DIVIDEND_BITS-1:0]    quotient
);
   import wlpg_pkg::*;

   logic [COORD_BITS-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0]  quo_ff, quo_in;
   logic [COORD_BITS-1:0]     div_ff, div_in;
   logic [DIV_COUNT_BITS-1:0] count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [COORD_BITS:0] shifted;
   logic [COORD_BITS:0] trial;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = !trial[COORD_BITS];

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
         count_in = DIV_COUNT_BITS'(DIVIDEND_BITS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

>>> rtl/wu_line_pixel_generator.sv
// wu line pixel generator: a load goes through accept, the gradient divide (one
// divider iteration per dividend bit), finish and the move to the output queue;
// the next item is taken once the sequencer is idle and the pair has left the pending
// register; step rate is set by the two result items sharing one output port and by
// the pair moving from the pending register only into the drained queue
// reset (synchronous, active high) clears sequencer, queue and line state
module wu_line_pixel_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [wlpg_pkg::COORD_BITS-1:0]   req_x_start,
   input  logic [wlpg_pkg::COORD_BITS-1:0]   req_y_start,
   input  logic [wlpg_pkg::COORD_BITS-1:0]   req_x_end,
   input  logic [wlpg_pkg::COORD_BITS-1:0]   req_y_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wlpg_pkg::COORD_BITS-1:0]   rsp_pixel_x,
   output logic [wlpg_pkg::COORD_BITS:0]     rsp_pixel_y,
   output logic                              rsp_line_last
);
   import wlpg_pkg::*;
`include "wu_line_pixel_generator_macros.svh"

   typedef enum logic {
      ST_IDLE,
      ST_DIV
   } state_type;

   state_type state_ff, state_in;

   // line state
   logic                    steep_ff, steep_in;
   logic [COORD_BITS-1:0]   column_ff, column_in;
   logic [COORD_BITS-1:0]   final_column_ff, final_column_in;
   logic [POS_BITS-1:0]     minor_position_ff, minor_position_in;
   logic [SLOPE_BITS-1:0]   slope_ff, slope_in;
   logic                    drawing_ff, drawing_in;

   // ordered endpoints held while the divider runs
   logic [COORD_BITS-1:0]   a1_ff, a1_in, b1_ff, b1_in;
   logic [COORD_BITS-1:0]   a2_ff, a2_in, b2_ff, b2_in;
   logic [COORD_BITS-1:0]   dx_ff, dx_in;
   logic                    dyneg_ff, dyneg_in;

   // pending pixel pair, then a two-entry output queue
   logic                    pend_valid_ff, pend_valid_in;
   pixel_type               pend0_ff, pend0_in, pend1_ff, pend1_in;
   logic                    q0_valid_ff, q0_valid_in, q1_valid_ff, q1_valid_in;
   pixel_type               q0_ff, q0_in, q1_ff, q1_in;

   logic req_take;
   logic rsp_take;
   logic transfer;

   // load-side decode of the incoming endpoints
   logic [COORD_BITS-1:0] adx, ady;
   logic                  steep_c;
   logic [COORD_BITS-1:0] sa1, sb1, sa2, sb2;
   logic [COORD_BITS-1:0] oa1, ob1, oa2, ob2;
   logic                  dyneg_c;
   logic [COORD_BITS-1:0] dymag_c;

   // divider
   logic                     div_start;
   div_status_type           div_status;
   logic [DIVIDEND_BITS-1:0] div_quotient;

   // load finish
   logic [SLOPE_BITS-1:0] mag_c;
   logic [SLOPE_BITS-1:0] slope_c;
   logic                  drawing_c;

   // step
   logic [COORD_BITS-1:0] floor_c;
   logic [COORD_BITS:0]   upper_c;
   logic                  last_c;
   logic [POS_BITS-1:0]   slope_ext;

   assign req_ready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = q0_valid_ff;
   assign rsp_take  = rsp_valid && rsp_ready;
   // the pair moves in only when the queue has drained
   assign transfer  = pend_valid_ff && !q0_valid_ff && !q1_valid_ff;

   assign rsp_pixel_x   = q0_ff.x;
   assign rsp_pixel_y   = q0_ff.y;
   assign rsp_line_last = q0_ff.last;

   // steepness and ordering by the major axis
   always_comb begin
      adx     = (req_x_start > req_x_end) ? req_x_start - req_x_end : req_x_end - req_x_start;
      ady     = (req_y_start > req_y_end) ? req_y_start - req_y_end : req_y_end - req_y_start;
      steep_c = adx < ady;
      sa1     = steep_c ? req_y_start : req_x_start;
      sb1     = steep_c ? req_x_start : req_y_start;
      sa2     = steep_c ? req_y_end   : req_x_end;
      sb2     = steep_c ? req_x_end   : req_y_end;
      if (sa2 < sa1) begin
         oa1 = sa2;
         ob1 = sb2;
         oa2 = sa1;
         ob2 = sb1;
      end else begin
         oa1 = sa1;
         ob1 = sb1;
         oa2 = sa2;
         ob2 = sb2;
      end
      dyneg_c = ob2 < ob1;
      dymag_c = dyneg_c ? ob1 - ob2 : ob2 - ob1;
   end

   assign div_start = req_take && (req_func == FUNC_LOAD);

   wlpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({dymag_c, {FRAC_BITS{1'b0}}}),
      .divisor  (oa2 - oa1),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // quotient never exceeds one, so FRAC_BITS+1 bits hold it
   always_comb begin
      mag_c     = {1'b0, div_quotient[FRAC_BITS:0]};
      if (dx_ff == '0) begin
         slope_c = '0;
      end else begin
         slope_c = dyneg_ff ? SLOPE_BITS'(-mag_c) : mag_c;
      end
      drawing_c = ({1'b0, a1_ff} + 1'b1) < {1'b0, a2_ff};
   end

   assign slope_ext = {{(POS_BITS - SLOPE_BITS){slope_ff[SLOPE_BITS-1]}}, slope_ff};
   assign floor_c   = minor_position_ff[POS_BITS-1:FRAC_BITS];
   assign upper_c   = {1'b0, floor_c} + 1'b1;
   assign last_c    = ({1'b0, column_ff} + 1'b1) >= {1'b0, final_column_ff};

   always_comb begin
      state_in          = state_ff;
      steep_in          = steep_ff;
      column_in         = column_ff;
      final_column_in   = final_column_ff;
      minor_position_in = minor_position_ff;
      slope_in          = slope_ff;
      drawing_in        = drawing_ff;
      a1_in             = a1_ff;
      b1_in             = b1_ff;
      a2_in             = a2_ff;
      b2_in             = b2_ff;
      dx_in             = dx_ff;
      dyneg_in          = dyneg_ff;
      pend_valid_in     = pend_valid_ff;
      pend0_in          = pend0_ff;
      pend1_in          = pend1_ff;
      q0_valid_in       = q0_valid_ff;
      q1_valid_in       = q1_valid_ff;
      q0_in             = q0_ff;
      q1_in             = q1_ff;

      // output queue: a transfer fills both entries, else a pop shifts the second entry forward
      if (transfer) begin
         q0_in         = pend0_ff;
         q1_in         = pend1_ff;
         q0_valid_in   = 1'b1;
         q1_valid_in   = 1'b1;
         pend_valid_in = 1'b0;
      end else if (rsp_take) begin
         q0_in       = q1_ff;
         q0_valid_in = q1_valid_ff;
         q1_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_func == FUNC_LOAD) begin
                  // abandon any active line, hold ordered endpoints
                  steep_in   = steep_c;
                  a1_in      = oa1;
                  b1_in      = ob1;
                  a2_in      = oa2;
                  b2_in      = ob2;
                  dx_in      = oa2 - oa1;
                  dyneg_in   = dyneg_c;
                  drawing_in = 1'b0;
                  state_in   = ST_DIV;
               end else if (drawing_ff) begin
                  // one interior column: lower and upper pixel
                  pend0_in          = make_pixel(steep_ff, column_ff, {1'b0, floor_c}, 1'b0);
                  pend1_in          = make_pixel(steep_ff, column_ff, upper_c, last_c);
                  pend_valid_in     = 1'b1;
                  minor_position_in = minor_position_ff + slope_ext;
                  column_in         = column_ff + 1'b1;
                  if (last_c) begin
                     drawing_in = 1'b0;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               slope_in          = slope_c;
               minor_position_in = {b1_ff, {FRAC_BITS{1'b0}}} +
                                   {{(POS_BITS - SLOPE_BITS){slope_c[SLOPE_BITS-1]}}, slope_c};
               column_in         = a1_ff + 1'b1;
               final_column_in   = a2_ff;
               drawing_in        = drawing_c;
               // endpoints in ordered form
               pend0_in          = make_pixel(steep_ff, a1_ff, {1'b0, b1_ff}, 1'b0);
               pend1_in          = make_pixel(steep_ff, a2_ff, {1'b0, b2_ff}, !drawing_c);
               pend_valid_in     = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         steep_ff          <= 1'b0;
         column_ff         <= '0;
         final_column_ff   <= '0;
         minor_position_ff <= '0;
         slope_ff          <= '0;
         drawing_ff        <= 1'b0;
         pend_valid_ff     <= 1'b0;
         q0_valid_ff       <= 1'b0;
         q1_valid_ff       <= 1'b0;
      end else begin
         state_ff          <= state_in;
         steep_ff          <= steep_in;
         column_ff         <= column_in;
         final_column_ff   <= final_column_in;
         minor_position_ff <= minor_position_in;
         slope_ff          <= slope_in;
         drawing_ff        <= drawing_in;
         pend_valid_ff     <= pend_valid_in;
         q0_valid_ff       <= q0_valid_in;
         q1_valid_ff       <= q1_valid_in;
      end
      a1_ff    <= a1_in;
      b1_ff    <= b1_in;
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
      dx_ff    <= dx_in;
      dyneg_ff <= dyneg_in;
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
      q0_ff    <= q0_in;
      q1_ff    <= q1_in;
   end

   // queue fills from the front
   `WLPG_ASSERT_NOW(a_queue_order, clock, reset, q1_valid_ff, q0_valid_ff, "queue tail without head")
   // no new item while the gradient is being formed
   `WLPG_ASSERT_NOW(a_busy_stall, clock, reset, div_status.busy, !req_ready, "ready during divide")
   // a moved pair shows up as two queued items
   `WLPG_ASSERT_NEXT(a_pair_moved, clock, reset, transfer, q0_valid_ff && q1_valid_ff && !pend_valid_ff, "pair lost on transfer")

endmodule

>>> test/wu_line_pixel_generator_test.sv
// testbench for the wu line pixel generator: drives load and step items, predicts
// every pixel from its own copy of the line state and checks results in order
// depends on wlpg_pkg and wu_line_pixel_generator only
`timescale 1ns / 100ps

module wu_line_pixel_generator_test;
   import wlpg_pkg::*;

   localparam int    HALF_PERIOD = 4;
   localparam int    MAX_COORD   = (1 << COORD_BITS) - 1;
   localparam longint POS_MASK   = (64'd1 << POS_BITS) - 1;
   localparam int    REPORT_MAX  = 10;

   // clock, reset and every block input start at a known value
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_func      = FUNC_LOAD;
   logic [COORD_BITS-1:0] req_x_start   = '0;
   logic [COORD_BITS-1:0] req_y_start   = '0;
   logic [COORD_BITS-1:0] req_x_end     = '0;
   logic [COORD_BITS-1:0] req_y_end     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [COORD_BITS-1:0] rsp_pixel_x;
   logic [COORD_BITS:0]   rsp_pixel_y;
   logic                  rsp_line_last;

   // traffic shaping, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int failure_count = 0;

   // pixels still owed by the block, oldest first
   pixel_type pending_pixels[$];

   // own copy of the line state
   logic                  line_steep  = 1'b0;
   logic [COORD_BITS-1:0] line_column = '0;
   logic [COORD_BITS-1:0] line_stop   = '0;
   longint                line_minor  = 0;
   longint                line_slope  = 0;
   logic                  line_active = 1'b0;

   wu_line_pixel_generator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_x_start   (req_x_start),
      .req_y_start   (req_y_start),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_line_last (rsp_line_last)
   );

   always #HALF_PERIOD clock = ~clock;

   // receiver side: stall decided fresh each cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------
   // pixel prediction
   // ---------------------------------------------------------------

   // queue one pixel given in major/minor axes, swapped back when steep
   function automatic void queue_pixel(input longint major, input longint minor,
                                       input logic last);
      pixel_type  p;
      logic [63:0] px;
      logic [63:0] py;
      px     = line_steep ? minor : major;
      py     = line_steep ? major : minor;
      p.x    = px[COORD_BITS-1:0];   // upper pixel of a steep line wraps here
      p.y    = py[COORD_BITS:0];
      p.last = last;
      pending_pixels.push_back(p);
   endfunction

   // advance the line state by one accepted item, return the pixel count
   function automatic int predict_pixels(input logic func,
                                         input int xs, input int ys,
                                         input int xe, input int ye);
      int     a1, b1, a2, b2, t, adx, ady, dx, dy;
      longint mag;
      longint pos;
      longint floor_minor;
      logic   last;
      if (func == FUNC_LOAD) begin
         a1  = xs;
         b1  = ys;
         a2  = xe;
         b2  = ye;
         adx = (a1 > a2) ? a1 - a2 : a2 - a1;
         ady = (b1 > b2) ? b1 - b2 : b2 - b1;
         line_steep = (adx < ady);
         // steep line: walk along y instead
         if (line_steep) begin
            t = a1; a1 = b1; b1 = t;
            t = a2; a2 = b2; b2 = t;
         end
         // order endpoints along the major axis
         if (a2 < a1) begin
            t = a1; a1 = a2; a2 = t;
            t = b1; b1 = b2; b2 = t;
         end
         dx = a2 - a1;
         dy = b2 - b1;
         // gradient magnitude truncates toward zero, sign applied after
         if (dx == 0) begin
            line_slope = 0;
         end else begin
            mag        = (longint'(dy < 0 ? -dy : dy) << FRAC_BITS) / dx;
            line_slope = (dy < 0) ? -mag : mag;
         end
         line_minor  = (longint'(b1) << FRAC_BITS) + line_slope;
         line_column = COORD_BITS'(a1 + 1);
         line_stop   = COORD_BITS'(a2);
         line_active = ((a1 + 1) < a2);
         queue_pixel(a1, b1, 1'b0);
         queue_pixel(a2, b2, !line_active);
         return 2;
      end
      // step with no line in progress is dropped
      if (!line_active) begin
         return 0;
      end
      pos         = (line_minor < 0) ? 0 : (line_minor & POS_MASK);
      floor_minor = pos >> FRAC_BITS;
      last        = ((longint'(line_column) + 1) >= longint'(line_stop));
      queue_pixel(line_column, floor_minor, 1'b0);
      queue_pixel(line_column, floor_minor + 1, last);
      line_minor  = line_minor + line_slope;
      line_column = line_column + 1'b1;
      if (last) begin
         line_active = 1'b0;
      end
      return 2;
   endfunction

   // interior columns still to be stepped on the current line
   function automatic int columns_left();
      return line_active ? int'(line_stop) - int'(line_column) : 0;
   endfunction

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            failure_count++;
            if (failure_count <= REPORT_MAX) begin
               $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                        rsp_pixel_x, rsp_pixel_y, rsp_line_last);
            end
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y ||
                rsp_line_last !== want.last) begin
               failure_count++;
               if (failure_count <= REPORT_MAX) begin
                  $display("%0t: pixel mismatch expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           $realtime, want.x, want.y, want.last,
                           rsp_pixel_x, rsp_pixel_y, rsp_line_last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------

   // drive one item from a falling edge, hold it until accepted, then predict;
   // valid stays up after acceptance so back-to-back items never toggle it
   task automatic send_item(input logic func,
                            input int xs, input int ys, input int xe, input int ye,
                            output int produced);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_x_start <= COORD_BITS'(xs);
      req_y_start <= COORD_BITS'(ys);
      req_x_end   <= COORD_BITS'(xe);
      req_y_end   <= COORD_BITS'(ye);
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      produced = predict_pixels(func, xs, ys, xe, ye);
   endtask

   task automatic send_load(input int xs, input int ys, input int xe, input int ye);
      int produced;
      send_item(FUNC_LOAD, xs, ys, xe, ye, produced);
   endtask

   // step items carry random junk in the unused coordinate fields
   task automatic send_steps(input int count, output int produced_steps);
      int produced;
      produced_steps = 0;
      repeat (count) begin
         send_item(FUNC_STEP, $urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
                   $urandom_range(MAX_COORD), $urandom_range(MAX_COORD), produced);
         if (produced != 0) begin
            produced_steps++;
         end
      end
   endtask

   // drop valid and hold off until every owed pixel has come back
   task automatic wait_for_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_traffic(input int send_pct, input int stall_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : ((v > MAX_COORD) ? MAX_COORD : v);
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // steps straight after reset have no line to work on
   task automatic test_idle_steps();
      int n;
      send_steps(2, n);
   endtask

   // single-point lines emit the same pixel twice; the far corner wraps the column
   task automatic test_zero_length();
      send_load(5, 7, 5, 7);
      send_load(0, 0, 0, 0);
      send_load(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
   endtask

   // full-range diagonals and a near-vertical steep line, each abandoned early
   task automatic test_extreme_lines();
      int n;
      send_load(0, 0, MAX_COORD, MAX_COORD);
      send_steps(2, n);
      // reversed endpoints, falling gradient, abandons the previous line
      send_load(MAX_COORD, 0, 0, MAX_COORD);
      send_steps(2, n);
      send_load(0, 0, 1, MAX_COORD);
      send_steps(1, n);
   endtask

   // upper pixel one past the range: wraps in x for steep, fits y for shallow
   task automatic test_upper_overflow();
      int n;
      send_load(MAX_COORD, 3, MAX_COORD, 0);
      send_steps(2, n);
      send_load(0, MAX_COORD, 3, MAX_COORD);
      send_steps(2, n);
      // line finished, this step is dropped
      send_steps(1, n);
   endtask

   // short steep line and a falling shallow line stepped to the end
   task automatic test_short_lines();
      int n;
      send_load(10, 10, 11, 12);
      send_steps(1, n);
      send_load(25, 27, 20, 30);
      send_steps(columns_left(), n);
   endtask

   // mostly short lines stepped to completion, with abandoned lines, surplus
   // steps, long lines and lines hugging the edges mixed in
   task automatic test_random_lines(input int item_budget);
      int sent;
      int kind;
      int xs, ys, xe, ye;
      int reach;
      int plan;
      int roll;
      int n;
      sent = 0;
      while (sent < item_budget) begin
         kind = $urandom_range(99);
         xs   = $urandom_range(MAX_COORD);
         ys   = $urandom_range(MAX_COORD);
         if (kind < 75) begin
            reach = $urandom_range(1, 12);
            xe    = clamp_coord(xs + $urandom_range(2 * reach) - reach);
            ye    = clamp_coord(ys + $urandom_range(2 * reach) - reach);
         end else if (kind < 87) begin
            xe = $urandom_range(MAX_COORD);
            ye = $urandom_range(MAX_COORD);
         end else begin
            // endpoints pinned to the borders
            xs = $urandom_range(1) ? MAX_COORD : $urandom_range(5);
            ys = $urandom_range(1) ? MAX_COORD - $urandom_range(5) : 0;
            xe = clamp_coord(xs + $urandom_range(16) - 8);
            ye = $urandom_range(1) ? ys : MAX_COORD;
         end
         send_load(xs, ys, xe, ye);
         sent++;
         roll = $urandom_range(99);
         if (roll < 75) begin
            plan = columns_left();
         end else if (roll < 88) begin
            plan = $urandom_range(columns_left());
         end else begin
            plan = columns_left() + $urandom_range(1, 3);
         end
         // long lines are cut short and left for the next load
         if (plan > 30) begin
            plan = $urandom_range(30);
         end
         send_steps(plan, n);
         sent += n;
         if ($urandom_range(99) < 5) begin
            wait_for_pixels();
         end
      end
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles less than the receiver stalls
      set_traffic(30, 76);
      test_idle_steps();
      test_zero_length();
      test_extreme_lines();
      test_upper_overflow();
      test_short_lines();
      wait_for_pixels();
      test_random_lines(150);
      wait_for_pixels();

      // receiver faster than the sender
      set_traffic(76, 30);
      test_random_lines(150);
      wait_for_pixels();

      // full rate on both sides
      set_traffic(0, 0);
      test_random_lines(150);
      wait_for_pixels();

      // catch stray pixels after the last load has settled
      repeat (40) @(posedge clock);
      if (failure_count == 0 && pending_pixels.size() == 0) begin
         $display("PASS wu_line_pixel_generator");
      end else begin
         $display("FAIL wu_line_pixel_generator");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("FAIL wu_line_pixel_generator");
      $finish;
   end

endmodule
